FILE: sv/cdcs_pkg.sv
// shared constants, types and the sigmoid breakpoint table for the depthwise conv block
package cdcs_pkg;

    localparam int MAX_TAPS_DEF = 4;
    localparam int CHANNELS_DEF = 1024;
    localparam int LAYERS_DEF   = 4;

    localparam int DATA_W   = 16;
    localparam int CFG_W    = 3;
    localparam int TAPS_RST = 4;

    localparam logic [63:0] EXP_STEP = 64'd4034748382;
    localparam logic [16:0] SIG_ONE  = 17'd32768;

    localparam logic REQ_LOAD   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef logic [15:0] sig_table_t [256];

    // sigmoid(-8 + i/16) in unsigned q1.15, evaluated at elaboration
    function automatic sig_table_t build_sigmoid_table();
        sig_table_t  tbl;
        logic [63:0] p;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] c;
        logic [63:0] num;
        logic [63:0] r;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            d   = (64'd1 << 32) + p;
            num = (64'd1 << 47) + (d >> 1);
            // restoring division, one quotient bit per step
            s = '0;
            r = '0;
            for (int b = 47; b >= 0; b--) begin
                r = {r[62:0], num[b]};
                if (r >= d) begin
                    r    = r - d;
                    s[b] = 1'b1;
                end
            end
            c = 64'd32768 - s;
            if (k < 128) begin
                tbl[128 + k] = s[15:0];
            end
            if (k >= 1) begin
                tbl[128 - k] = c[15:0];
            end
            p = (p * EXP_STEP + (64'd1 << 31)) >> 32;
        end
        return tbl;
    endfunction

    localparam sig_table_t SIG_TABLE = build_sigmoid_table();

endpackage

FILE: sv/cdcs_kern_mem.sv
// kernel weight memory, one row of taps per layer and channel, single-tap writes
module cdcs_kern_mem #(
    parameter int MAX_TAPS = cdcs_pkg::MAX_TAPS_DEF,
    parameter int ROWS     = cdcs_pkg::CHANNELS_DEF * cdcs_pkg::LAYERS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
    input  logic [$clog2(MAX_TAPS)-1:0]            wr_tap,
    input  logic [cdcs_pkg::DATA_W-1:0]            wr_data,
    input  logic                                   rd_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
    output logic [MAX_TAPS*cdcs_pkg::DATA_W-1:0]   rd_data
);

    localparam int ROW_BITS = MAX_TAPS * cdcs_pkg::DATA_W;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row][wr_tap*cdcs_pkg::DATA_W +: cdcs_pkg::DATA_W] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/cdcs_hist_mem.sv
// history memory, one row of past samples per layer and channel
module cdcs_hist_mem #(
    parameter int SLOTS = cdcs_pkg::MAX_TAPS_DEF - 1,
    parameter int ROWS  = cdcs_pkg::CHANNELS_DEF * cdcs_pkg::LAYERS_DEF
) (
    input  logic                                   aclk,
    input  logic                                   wr_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] wr_row,
    input  logic [SLOTS*cdcs_pkg::DATA_W-1:0]      wr_data,
    input  logic                                   rd_en,
    input  logic [((ROWS > 1) ? $clog2(ROWS) : 1)-1:0] rd_row,
    output logic [SLOTS*cdcs_pkg::DATA_W-1:0]      rd_data
);

    localparam int ROW_BITS = SLOTS * cdcs_pkg::DATA_W;

    logic [ROW_BITS-1:0] mem [ROWS];
    logic [ROW_BITS-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_row] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_row];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: sv/cdcs_silu.sv
// four-stage silu: table lookup, interpolation, product, rounding and saturation
module cdcs_silu #(
    parameter int XW = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic signed [XW-1:0]  x,
    output logic                  done,
    output logic signed [15:0]    y
);

    logic               v1_reg, v2_reg, v3_reg, v4_reg;
    logic               hi1_reg, lo1_reg, hi2_reg, lo2_reg, hi3_reg, lo3_reg;
    logic signed [16:0] x1_reg, x2_reg, x3_reg;
    logic [15:0]        tlo_reg;
    logic signed [17:0] diff_reg;
    logic [7:0]         f_reg;
    logic [16:0]        sig_reg;
    logic signed [34:0] prod_reg;
    logic signed [15:0] y_reg;

    logic               sat_hi, sat_lo;
    logic [15:0]        u;
    logic [7:0]         idx;
    logic [16:0]        t_lo, t_hi;
    logic signed [26:0] interp;
    logic signed [34:0] rnd;
    logic signed [19:0] ysh;
    logic signed [15:0] y_next;

    // in range exactly when the top bits all match the q4.12 sign bit
    assign sat_hi = !x[XW-1] && (x[XW-2:15] != '0);
    assign sat_lo = x[XW-1] && (x[XW-2:15] != '1);
    assign u      = {~x[15], x[14:0]};
    assign idx    = u[15:8];
    assign t_lo   = {1'b0, cdcs_pkg::SIG_TABLE[idx]};
    assign t_hi   = (idx == 8'hFF) ? cdcs_pkg::SIG_ONE
                                   : {1'b0, cdcs_pkg::SIG_TABLE[idx + 8'd1]};

    assign interp = $signed({3'b000, tlo_reg, 8'h00}) + diff_reg * $signed({1'b0, f_reg})
                  + 27'sd128;

    assign rnd = prod_reg + 35'sd16384;
    assign ysh = rnd[34:15];

    always_comb begin
        if (hi3_reg) begin
            y_next = 16'sh7FFF;
        end else if (lo3_reg) begin
            y_next = '0;
        end else if (ysh > 20'sd32767) begin
            y_next = 16'sh7FFF;
        end else if (ysh < -20'sd32768) begin
            y_next = 16'sh8000;
        end else begin
            y_next = ysh[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v1_reg <= start;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            hi1_reg  <= sat_hi;
            lo1_reg  <= sat_lo;
            x1_reg   <= x[16:0];
            tlo_reg  <= t_lo[15:0];
            diff_reg <= $signed({1'b0, t_hi}) - $signed({1'b0, t_lo});
            f_reg    <= u[7:0];
        end
        if (v1_reg) begin
            hi2_reg <= hi1_reg;
            lo2_reg <= lo1_reg;
            x2_reg  <= x1_reg;
            sig_reg <= interp[24:8];
        end
        if (v2_reg) begin
            hi3_reg  <= hi2_reg;
            lo3_reg  <= lo2_reg;
            x3_reg   <= x2_reg;
            prod_reg <= x2_reg * $signed({1'b0, sig_reg});
        end
        if (v3_reg) begin
            y_reg <= y_next;
        end
    end

    assign done = v4_reg;
    assign y    = y_reg;

endmodule

FILE: sv/causal_depthwise_conv_silu.sv
// top level: request handling, history clearing pass, tap accumulator and result register
//
// Input items arrive on the s_axis channel: tuser selects a kernel-tap load
// (0) or a sample (1), tdata carries layer, channel, tap and a q4.12 value.
// Each in-range sample yields one transfer on m_axis with the saturated silu
// of the causal convolution; loads and out-of-range items give nothing.
// A load is written to the kernel memory as it is taken. A sample passes from its
// transfer to the output register (K the kernel length in use) through the
// memory read, the single-multiplier tap accumulator over the K taps, rounding,
// the silu pipeline and the write-back of the shifted history row. No new item
// is taken until the block is back in idle.
// Kernel length is set through cfg_valid/cfg_data (reset value 4) and may
// only change while the block is idle.
// After reset the block sweeps the history memory to zero, one row per cycle,
// all LAYERS * CHANNELS rows (4096 by default); s_axis_tready stays low until
// then. A result waits in the output register while m_axis_tready is low;
// the block keeps accepting items and only holds a new sample at write-back.
module causal_depthwise_conv_silu #(
    parameter int MAX_TAPS = cdcs_pkg::MAX_TAPS_DEF,
    parameter int CHANNELS = cdcs_pkg::CHANNELS_DEF,
    parameter int LAYERS   = cdcs_pkg::LAYERS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // layer, channel, tap, value, zero pad
    input  logic [0:0]  s_axis_tuser,   // req_type
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // activation, out_layer, out_channel, zero pad
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [cdcs_pkg::CFG_W-1:0] cfg_data
);

    localparam int DW     = cdcs_pkg::DATA_W;
    localparam int SLOTS  = MAX_TAPS - 1;
    localparam int ROWS   = LAYERS * CHANNELS;
    localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int TIDX_W = $clog2(MAX_TAPS);
    localparam int K_W    = $clog2(MAX_TAPS + 1);
    localparam int ACC_W  = 2 * DW + K_W;
    localparam int XW     = ACC_W - 12;

    typedef enum logic [6:0] {
        S_CLEAR = 7'b0000001,
        S_IDLE  = 7'b0000010,
        S_READ  = 7'b0000100,
        S_MAC   = 7'b0001000,
        S_RND   = 7'b0010000,
        S_SILU  = 7'b0100000,
        S_WB    = 7'b1000000
    } state_t;

    state_t                     state_reg, state_next;
    logic [ROW_W-1:0]           clr_reg, clr_next;
    logic [cdcs_pkg::CFG_W-1:0] taps_reg;
    logic [K_W-1:0]             k_reg, k_eff;
    logic [TIDX_W-1:0]          t_reg, t_next;
    logic signed [ACC_W-1:0]    acc_reg, acc_next;
    logic [ROW_W-1:0]           row_reg;
    logic [1:0]                 layer_reg;
    logic [9:0]                 chan_reg;
    logic signed [DW-1:0]       val_reg;
    logic                       m_valid_reg;
    logic [15:0]                act_reg;
    logic [1:0]                 olayer_reg;
    logic [9:0]                 ochan_reg;

    logic [1:0]             in_layer;
    logic [9:0]             in_chan;
    logic [1:0]             in_tap;
    logic [DW-1:0]          in_val;
    logic                   in_acc, in_range, tap_ok;
    logic [ROW_W-1:0]       in_row;
    logic [K_W-1:0]         taps_ext;

    logic [SLOTS*DW-1:0]    hist_rdata, hist_wdata;
    logic [MAX_TAPS*DW-1:0] kern_rdata;
    logic signed [DW-1:0]   hist_q [MAX_TAPS];
    logic signed [DW-1:0]   kern_q [MAX_TAPS];
    logic signed [DW-1:0]   mac_a;
    logic signed [2*DW-1:0] mac_p;
    logic                   mac_last;
    logic signed [ACC_W-1:0] acc_rnd;
    logic                   hist_we, out_free;
    logic [ROW_W-1:0]       hist_wrow;
    logic                   silu_done;
    logic signed [15:0]     silu_y;

    assign in_layer = s_axis_tdata[1:0];
    assign in_chan  = s_axis_tdata[11:2];
    assign in_tap   = s_axis_tdata[13:12];
    assign in_val   = s_axis_tdata[29:14];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_range      = (32'(in_layer) < LAYERS) && (32'(in_chan) < CHANNELS);
    assign tap_ok        = (32'(in_tap) < MAX_TAPS);
    assign in_row        = ROW_W'(32'(in_layer) * CHANNELS + 32'(in_chan));

    assign cfg_ready = 1'b1;

    // kernel length clamped to the supported range
    assign taps_ext = K_W'(taps_reg);
    always_comb begin
        if (32'(taps_reg) < 2) begin
            k_eff = K_W'(2);
        end else if (32'(taps_reg) > MAX_TAPS) begin
            k_eff = K_W'(MAX_TAPS);
        end else begin
            k_eff = taps_ext;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_TAPS; j++) begin
            kern_q[j] = kern_rdata[j*DW +: DW];
            if (j < SLOTS) begin
                hist_q[j] = hist_rdata[j*DW +: DW];
            end else begin
                hist_q[j] = '0;
            end
        end
    end

    assign mac_last = (K_W'(t_reg) == k_reg - K_W'(1));
    assign mac_a    = mac_last ? val_reg : hist_q[t_reg];
    assign mac_p    = mac_a * kern_q[t_reg];
    assign acc_rnd  = acc_reg + ACC_W'(2048);

    // shift the older samples down and append the new one at slot k-2; zeros during the clearing pass
    always_comb begin
        for (int j = 0; j < SLOTS; j++) begin
            if (j + 2 < 32'(k_reg)) begin
                hist_wdata[j*DW +: DW] = hist_q[j+1];
            end else if (j + 2 == 32'(k_reg)) begin
                hist_wdata[j*DW +: DW] = val_reg;
            end else begin
                hist_wdata[j*DW +: DW] = hist_q[j];
            end
        end
        if (state_reg == S_CLEAR) begin
            hist_wdata = '0;
        end
    end

    assign out_free  = !m_valid_reg || m_axis_tready;
    assign hist_we   = (state_reg == S_CLEAR) || ((state_reg == S_WB) && out_free);
    assign hist_wrow = (state_reg == S_CLEAR) ? clr_reg : row_reg;

    always_comb begin
        state_next = state_reg;
        clr_next   = clr_reg;
        t_next     = t_reg;
        acc_next   = acc_reg;
        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + ROW_W'(1);
                if (clr_reg == ROW_W'(ROWS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_acc && in_range && (s_axis_tuser[0] == cdcs_pkg::REQ_SAMPLE)) begin
                    state_next = S_READ;
                end
            end
            S_READ: begin
                t_next     = '0;
                acc_next   = '0;
                state_next = S_MAC;
            end
            S_MAC: begin
                acc_next = acc_reg + ACC_W'(mac_p);
                t_next   = t_reg + TIDX_W'(1);
                if (mac_last) begin
                    state_next = S_RND;
                end
            end
            S_RND: begin
                state_next = S_SILU;
            end
            S_SILU: begin
                if (silu_done) begin
                    state_next = S_WB;
                end
            end
            S_WB: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_CLEAR;
                clr_next   = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            taps_reg    <= cdcs_pkg::CFG_W'(cdcs_pkg::TAPS_RST);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            if (cfg_valid && cfg_ready) begin
                taps_reg <= cfg_data;
            end
            if ((state_reg == S_WB) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        t_reg   <= t_next;
        acc_reg <= acc_next;
        if (in_acc) begin
            row_reg   <= in_row;
            layer_reg <= in_layer;
            chan_reg  <= in_chan;
            val_reg   <= in_val;
            k_reg     <= k_eff;
        end
        if ((state_reg == S_WB) && out_free) begin
            act_reg    <= silu_y;
            olayer_reg <= layer_reg;
            ochan_reg  <= chan_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0000, ochan_reg, olayer_reg, act_reg};

    cdcs_kern_mem #(
        .MAX_TAPS (MAX_TAPS),
        .ROWS     (ROWS)
    ) u_kern (
        .aclk    (aclk),
        .wr_en   (in_acc && in_range && tap_ok
                  && (s_axis_tuser[0] == cdcs_pkg::REQ_LOAD)),
        .wr_row  (in_row),
        .wr_tap  (TIDX_W'(in_tap)),
        .wr_data (in_val),
        .rd_en   (state_reg == S_READ),
        .rd_row  (row_reg),
        .rd_data (kern_rdata)
    );

    cdcs_hist_mem #(
        .SLOTS (SLOTS),
        .ROWS  (ROWS)
    ) u_hist (
        .aclk    (aclk),
        .wr_en   (hist_we),
        .wr_row  (hist_wrow),
        .wr_data (hist_wdata),
        .rd_en   (state_reg == S_READ),
        .rd_row  (row_reg),
        .rd_data (hist_rdata)
    );

    cdcs_silu #(
        .XW (XW)
    ) u_silu (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (state_reg == S_RND),
        .x       (acc_rnd[ACC_W-1:12]),
        .done    (silu_done),
        .y       (silu_y)
    );

endmodule

FILE: dv/conv_silu_checker.sv
// checker: watches the depthwise conv channels, predicts every activation and compares it
module conv_silu_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_axis_tvalid,
    input  logic                       s_axis_tready,
    input  logic [31:0]                s_axis_tdata,   // layer, channel, tap, value, zero pad
    input  logic [0:0]                 s_axis_tuser,   // req_type
    input  logic                       m_axis_tvalid,
    input  logic                       m_axis_tready,
    input  logic [31:0]                m_axis_tdata,   // activation, out_layer, out_channel, zero pad
    input  logic                       cfg_valid,
    input  logic                       cfg_ready,
    input  logic [cdcs_pkg::CFG_W-1:0] cfg_data,
    output int                         mismatches,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int HIST_SLOTS = cdcs_pkg::MAX_TAPS_DEF - 1;

    typedef struct packed {
        logic signed [15:0] act;
        logic [1:0]         layer;
        logic [9:0]         channel;
    } conv_result_t;

    conv_result_t       awaited_q[$];
    logic signed [15:0] weights [cdcs_pkg::LAYERS_DEF][cdcs_pkg::CHANNELS_DEF]
                                [cdcs_pkg::MAX_TAPS_DEF];
    logic signed [15:0] history [cdcs_pkg::LAYERS_DEF][HIST_SLOTS][cdcs_pkg::CHANNELS_DEF];
    logic [15:0]        sig_points [256];
    logic [cdcs_pkg::CFG_W-1:0] kernel_len;
    int                 err_count;

    // sigmoid(-8 + i/16) breakpoints in unsigned q1.15
    initial begin
        longint unsigned p;
        longint unsigned d;
        longint unsigned s;
        p = 64'd1 << 32;
        for (int k = 0; k <= 128; k++) begin
            d = (64'd1 << 32) + p;
            s = ((64'd1 << 47) + d / 2) / d;
            if (k < 128) sig_points[128 + k] = 16'(s);
            if (k >= 1) sig_points[128 - k] = 16'(64'd32768 - s);
            p = (p * 64'd4034748382 + (64'd1 << 31)) >> 32;
        end
    end

    function automatic logic signed [15:0] silu_q412(longint x);
        longint sig;
        longint u;
        longint lo;
        longint hi;
        longint y;
        if (x >= 32768) begin
            sig = 32768;
        end else if (x < -32768) begin
            sig = 0;
        end else begin
            u   = x + 32768;
            lo  = sig_points[u >> 8];
            hi  = ((u >> 8) < 255) ? longint'(sig_points[(u >> 8) + 1]) : 32768;
            sig = (lo * (256 - (u & 255)) + hi * (u & 255) + 128) >>> 8;
        end
        y = (x * sig + 16384) >>> 15;
        if (y > 32767) y = 32767;
        if (y < -32768) y = -32768;
        return 16'(y);
    endfunction

    // convolution over the channel history, then shift the new sample in
    function automatic conv_result_t convolve_sample(int lay, int ch, logic signed [15:0] val);
        conv_result_t r;
        int           k;
        longint       acc;
        k = (kernel_len < 2) ? 2 :
            (kernel_len > cdcs_pkg::MAX_TAPS_DEF) ? cdcs_pkg::MAX_TAPS_DEF : int'(kernel_len);
        acc = 0;
        for (int t = 0; t < k - 1; t++) begin
            acc += longint'(history[lay][t][ch]) * longint'(weights[lay][ch][t]);
        end
        acc += longint'(val) * longint'(weights[lay][ch][k - 1]);
        r.act     = silu_q412((acc + 2048) >>> 12);
        r.layer   = 2'(lay);
        r.channel = 10'(ch);
        for (int t = 0; t < k - 2; t++) begin
            history[lay][t][ch] = history[lay][t + 1][ch];
        end
        history[lay][k - 2][ch] = val;
        return r;
    endfunction

    task automatic log_mismatch(string what, conv_result_t want, conv_result_t got);
        err_count++;
        if (err_count <= 10) begin
            $display("%0t ns: %s: expected act=%0d layer=%0d ch=%0d", $time, what,
                     want.act, want.layer, want.channel);
            $display("    got act=%0d layer=%0d ch=%0d", got.act, got.layer, got.channel);
        end
    endtask

    always @(posedge aclk) begin
        conv_result_t got;
        conv_result_t want;
        int           lay;
        int           ch;
        if (!aresetn) begin
            awaited_q.delete();
            kernel_len = cdcs_pkg::CFG_W'(cdcs_pkg::TAPS_RST);
            foreach (history[l, t, c]) history[l][t][c] = '0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                kernel_len = cfg_data;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                lay = s_axis_tdata[1:0];
                ch  = s_axis_tdata[11:2];
                if (s_axis_tuser[0] == cdcs_pkg::REQ_LOAD) begin
                    weights[lay][ch][s_axis_tdata[13:12]] = s_axis_tdata[29:14];
                end else begin
                    awaited_q.push_back(convolve_sample(lay, ch, s_axis_tdata[29:14]));
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[17:16], m_axis_tdata[27:18]};
                if (awaited_q.size() == 0) begin
                    log_mismatch("result with none pending", '0, got);
                end else begin
                    want = awaited_q.pop_front();
                    if (got !== want) log_mismatch("activation mismatch", want, got);
                end
            end
        end
        pending    <= awaited_q.size();
        mismatches <= err_count;
    end

endmodule

FILE: dv/testbench.sv
// testbench top: drives loads, samples and kernel lengths into the conv block and gives the verdict
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // layer, channel, tap, value, zero pad
    logic [0:0]  s_axis_tuser = '0;   // req_type
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [31:0] m_axis_tdata;        // activation, out_layer, out_channel, zero pad
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [cdcs_pkg::CFG_W-1:0] cfg_data = '0;

    int mismatches;
    int pending;
    bit no_idle = 1'b0;
    int stall_left = 0;
    int ready_keys[$];

    always #5ns aclk = ~aclk;

    causal_depthwise_conv_silu uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    conv_silu_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .pending       (pending)
    );

    // mostly short, now and then long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [15:0] rand_q412();
        case ($urandom_range(0, 3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8192) - 4096);
            2: return 16'($urandom_range(0, 32767) - 16384);
            default: begin
                case ($urandom_range(0, 3))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh1000;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    always @(negedge aclk) begin
        if (no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left    <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 99) < 25) begin
            stall_left    <= gap_len() - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    task automatic push_item(logic req, int lay, int ch, int tap, logic signed [15:0] val);
        int gap;
        gap = (no_idle || $urandom_range(0, 1) == 0) ? 0 : gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_axis_tdata  <= {2'b00, val, 2'(tap), 10'(ch), 2'(lay)};
        s_axis_tuser  <= req;
        s_axis_tvalid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (s_axis_tready) break;
        end
        @(negedge aclk);
    endtask

    // a load may still be in flight once the last result is out
    task automatic hold_until_drained();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (20) @(negedge aclk);
    endtask

    task automatic write_kernel_len(int len);
        hold_until_drained();
        cfg_data  <= 3'(len);
        cfg_valid <= 1'b1;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic remember_key(int lay, int ch);
        ready_keys.push_back(lay * 1024 + ch);
        if (ready_keys.size() > 16) void'(ready_keys.pop_front());
    endtask

    task automatic run_phase(int n_items);
        int sent;
        int r;
        int lay;
        int ch;
        int key;
        int first;
        int step;
        sent = 0;
        while (sent < n_items) begin
            if (sent % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
            if (sent == n_items / 2) hold_until_drained();
            r = $urandom_range(0, 99);
            if (ready_keys.size() == 0 || r < 12) begin
                // full kernel load in a random tap order
                lay   = $urandom_range(0, 3);
                ch    = $urandom_range(0, 1023);
                first = $urandom_range(0, 3);
                step  = $urandom_range(0, 1) ? 1 : 3;
                for (int i = 0; i < 4; i++) begin
                    push_item(cdcs_pkg::REQ_LOAD, lay, ch, (first + i * step) % 4, rand_q412());
                end
                sent += 4;
                remember_key(lay, ch);
            end else if (r < 18) begin
                // broken load sequence, the channel is sampled only if fully loaded before or later
                lay = $urandom_range(0, 3);
                ch  = $urandom_range(0, 1023);
                repeat ($urandom_range(1, 3)) begin
                    push_item(cdcs_pkg::REQ_LOAD, lay, ch, $urandom_range(0, 3), rand_q412());
                    sent++;
                end
            end else begin
                key = ready_keys[$urandom_range(0, ready_keys.size() - 1)];
                push_item(cdcs_pkg::REQ_SAMPLE, key / 1024, key % 1024, $urandom_range(0, 3),
                          rand_q412());
                sent++;
            end
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int lengths[8];
        lengths = '{2, 7, 3, 0, 4, 1, 6, 5};
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // extremes on the first and last channel, default kernel length
        push_item(cdcs_pkg::REQ_LOAD, 0, 0, 0, 16'sh7fff);
        push_item(cdcs_pkg::REQ_LOAD, 0, 0, 1, 16'sh8000);
        push_item(cdcs_pkg::REQ_LOAD, 0, 0, 2, 16'sh0000);
        push_item(cdcs_pkg::REQ_LOAD, 0, 0, 3, 16'sh1000);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 0, 16'sh1000);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 1, 16'sh7fff);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 2, 16'sh8000);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 3, 16'sh0000);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 0, -16'sh1000);
        for (int t = 0; t < 4; t++) push_item(cdcs_pkg::REQ_LOAD, 3, 1023, t, 16'sh8000);
        push_item(cdcs_pkg::REQ_SAMPLE, 3, 1023, 3, 16'sh8000);
        push_item(cdcs_pkg::REQ_SAMPLE, 3, 1023, 3, 16'sh8000);
        push_item(cdcs_pkg::REQ_SAMPLE, 3, 1023, 3, 16'sh7fff);
        push_item(cdcs_pkg::REQ_SAMPLE, 3, 1023, 3, 16'sh0800);
        push_item(cdcs_pkg::REQ_LOAD, 0, 0, 3, 16'sh7fff);
        push_item(cdcs_pkg::REQ_SAMPLE, 0, 0, 3, 16'sh7fff);
        remember_key(0, 0);
        remember_key(3, 1023);

        // every kernel length, out-of-range ones included, histories carried across
        foreach (lengths[i]) begin
            write_kernel_len(lengths[i]);
            run_phase(125);
        end

        hold_until_drained();
        repeat (10) @(negedge aclk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #10ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/cdcs_pkg.sv
sv/cdcs_kern_mem.sv
sv/cdcs_hist_mem.sv
sv/cdcs_silu.sv
sv/causal_depthwise_conv_silu.sv
dv/conv_silu_checker.sv
dv/testbench.sv
